FILE: hdl/wsc_pkg.sv
package wsc_pkg;

  localparam logic [2:0] CMD_TICK          = 3'd0;
  localparam logic [2:0] CMD_LENGTH_CLOCK  = 3'd1;
  localparam logic [2:0] CMD_REG_WRITE     = 3'd2;
  localparam logic [2:0] CMD_REG_READ      = 3'd3;
  localparam logic [2:0] CMD_PATTERN_WRITE = 3'd4;
  localparam logic [2:0] CMD_PATTERN_READ  = 3'd5;
  localparam logic [2:0] CMD_POWER_OFF     = 3'd6;

  localparam logic [7:0] REG_DAC     = 8'h1A;
  localparam logic [7:0] REG_LENGTH  = 8'h1B;
  localparam logic [7:0] REG_VOLUME  = 8'h1C;
  localparam logic [7:0] REG_FREQ_LO = 8'h1D;
  localparam logic [7:0] REG_FREQ_HI = 8'h1E;

  localparam logic [7:0]  READ_IDLE      = 8'hFF;
  localparam logic [7:0]  DAC_READ_MASK  = 8'h7F;
  localparam logic [7:0]  VOL_READ_MASK  = 8'h9F;
  localparam logic [7:0]  FREQ_READ_MASK = 8'h87;
  localparam logic [11:0] PERIOD_BASE    = 12'd2048;
  localparam logic [8:0]  LENGTH_FULL    = 9'd256;
  localparam logic [12:0] TIMER_RESET    = 13'd4096;

  localparam int unsigned PATTERN_BYTES = 16;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] reg_address;
    logic [3:0] pattern_offset;
    logic [7:0] write_data;
  } wsc_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] sample_out;
    logic       channel_active;
  } wsc_out_t;

  function automatic logic [12:0] reload_value(input logic [10:0] period);
    logic [11:0] diff;
    diff = PERIOD_BASE - {1'b0, period};
    return {diff, 1'b0};
  endfunction

endpackage

FILE: hdl/wavetable_sound_channel_core.sv
// Wavetable sound channel with 16 bytes of pattern RAM holding 32 four-bit samples.
// Input channel (in_valid/in_ready/in_data): one beat carries a command, a register
// address, a pattern offset and a write byte. Commands are tick, length clock,
// register write and read, pattern write and read, and power off.
// Output channel (out_valid/out_ready/out_data): exactly one beat per input beat,
// carrying the read byte (0xFF for non-read commands), the current output sample
// and the channel active flag, all as they stand after the command.
// A result is registered in the output register, or in the second buffer entry
// on a stall. Throughput is one beat per cycle while in_ready is high; every command
// is handled in a single pass of logic between state and output registers.
// A two-entry output buffer lets the block take a new beat while a result waits;
// in_ready drops only when both entries are full, so a stalled receiver holds
// results in order and nothing is lost.
// Synchronous reset clears all channel state and the pattern RAM, loads the
// period timer with 4096 and empties the output buffer.
module wavetable_sound_channel_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsc_pkg::wsc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wsc_pkg::wsc_out_t out_data
);
  import wsc_pkg::*;

  logic [12:0] timer_r, timer_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [8:0]  length_r, length_nxt;
  logic        on_r, on_nxt;
  logic        dac_r, dac_nxt;
  logic [1:0]  vol_r, vol_nxt;
  logic [10:0] period_r, period_nxt;
  logic        len_en_r, len_en_nxt;
  logic [3:0]  sample_r, sample_nxt;
  logic [7:0]  pattern_r [PATTERN_BYTES];

  wsc_out_t    out_r, skid_r, result;
  logic        out_valid_r, skid_valid_r;
  logic        accept, pop;

  logic [12:0] timer_dec;
  logic [4:0]  tick_pos;
  logic [3:0]  rd_index;
  logic [7:0]  rd_byte;
  logic [3:0]  nibble;
  logic [1:0]  shift_amt;
  logic [7:0]  read_nxt;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign timer_dec = timer_r - 13'd1;
  assign tick_pos  = (timer_dec == 13'd0) ? pos_r + 5'd1 : pos_r;
  assign rd_index  = (in_data.cmd == CMD_TICK) ? tick_pos[4:1] : in_data.pattern_offset;
  assign rd_byte   = pattern_r[rd_index];
  assign nibble    = tick_pos[0] ? rd_byte[7:4] : rd_byte[3:0];
  assign shift_amt = vol_r - 2'd1;

  always_comb begin
    timer_nxt  = timer_r;
    pos_nxt    = pos_r;
    length_nxt = length_r;
    on_nxt     = on_r;
    dac_nxt    = dac_r;
    vol_nxt    = vol_r;
    period_nxt = period_r;
    len_en_nxt = len_en_r;
    sample_nxt = sample_r;
    read_nxt   = READ_IDLE;
    case (in_data.cmd)
      CMD_TICK: begin
        if (timer_dec == 13'd0) begin
          timer_nxt = reload_value(period_r);
          pos_nxt   = pos_r + 5'd1;
        end else begin
          timer_nxt = timer_dec;
        end
        if (on_r && vol_r != 2'd0 && dac_r) begin
          sample_nxt = nibble >> shift_amt;
        end else begin
          sample_nxt = 4'd0;
        end
      end
      CMD_LENGTH_CLOCK: begin
        if (length_r != 9'd0 && len_en_r) begin
          length_nxt = length_r - 9'd1;
          if (length_r == 9'd1) begin
            on_nxt = 1'b0;
          end
        end
      end
      CMD_REG_WRITE: begin
        case (in_data.reg_address)
          REG_DAC:     dac_nxt = in_data.write_data[7];
          REG_LENGTH:  length_nxt = LENGTH_FULL - {1'b0, in_data.write_data};
          REG_VOLUME:  vol_nxt = in_data.write_data[6:5];
          REG_FREQ_LO: period_nxt = {period_r[10:8], in_data.write_data};
          REG_FREQ_HI: begin
            period_nxt = {in_data.write_data[2:0], period_r[7:0]};
            len_en_nxt = in_data.write_data[6];
            if (in_data.write_data[7]) begin
              on_nxt    = 1'b1;
              timer_nxt = reload_value(period_nxt);
              pos_nxt   = 5'd0;
              if (length_r == 9'd0) begin
                length_nxt = LENGTH_FULL;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_REG_READ: begin
        case (in_data.reg_address)
          REG_DAC:     read_nxt = {dac_r, 7'd0} | DAC_READ_MASK;
          REG_VOLUME:  read_nxt = {1'b0, vol_r, 5'd0} | VOL_READ_MASK;
          REG_FREQ_HI: read_nxt = {1'b0, len_en_r, 6'd0} | FREQ_READ_MASK;
          default:     read_nxt = READ_IDLE;
        endcase
      end
      CMD_PATTERN_READ: read_nxt = rd_byte;
      CMD_POWER_OFF: begin
        dac_nxt    = 1'b0;
        vol_nxt    = 2'd0;
        period_nxt = 11'd0;
        len_en_nxt = 1'b0;
      end
      default: ;
    endcase
    result.read_data      = read_nxt;
    result.sample_out     = sample_nxt;
    result.channel_active = on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r  <= TIMER_RESET;
      pos_r    <= 5'd0;
      length_r <= 9'd0;
      on_r     <= 1'b0;
      dac_r    <= 1'b0;
      vol_r    <= 2'd0;
      period_r <= 11'd0;
      len_en_r <= 1'b0;
      sample_r <= 4'd0;
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        pattern_r[4'(i)] <= 8'd0;
      end
    end else if (accept) begin
      timer_r  <= timer_nxt;
      pos_r    <= pos_nxt;
      length_r <= length_nxt;
      on_r     <= on_nxt;
      dac_r    <= dac_nxt;
      vol_r    <= vol_nxt;
      period_r <= period_nxt;
      len_en_r <= len_en_nxt;
      sample_r <= sample_nxt;
      if (in_data.cmd == CMD_PATTERN_WRITE) begin
        pattern_r[in_data.pattern_offset] <= in_data.write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wsc_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int unsigned RANDOM_BEATS = 950;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLDOFF_START = 300;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  wsc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  wsc_out_t out_data;

  wsc_in_t  pending_beats[$];
  wsc_out_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;

  logic [12:0] ch_timer;
  logic [4:0]  ch_pos;
  logic [8:0]  ch_len;
  logic        ch_on;
  logic        ch_dac;
  logic [1:0]  ch_vol;
  logic [10:0] ch_period;
  logic        ch_len_en;
  logic [3:0]  ch_sample;
  logic [7:0]  ch_ram [PATTERN_BYTES];

  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  int unsigned pattern_left = 0;
  int unsigned ready_mode = 0;

  wavetable_sound_channel_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [12:0] timer_reload(input logic [10:0] period);
    return 13'((14'(PERIOD_BASE) - 14'(period)) << 1);
  endfunction

  function automatic wsc_out_t predict_channel(input wsc_in_t beat);
    wsc_out_t   res;
    logic [7:0] pattern_byte;
    logic [3:0] nibble;
    res = '0;
    res.read_data = READ_IDLE;
    case (beat.cmd)
      CMD_TICK: begin
        ch_timer = ch_timer - 13'd1;
        if (ch_timer == 13'd0) begin
          ch_timer = timer_reload(ch_period);
          ch_pos = ch_pos + 5'd1;
        end
        if (ch_on && ch_vol != 2'd0 && ch_dac) begin
          pattern_byte = ch_ram[ch_pos[4:1]];
          nibble = ch_pos[0] ? pattern_byte[7:4] : pattern_byte[3:0];
          ch_sample = nibble >> (ch_vol - 2'd1);
        end else begin
          ch_sample = 4'd0;
        end
      end
      CMD_LENGTH_CLOCK: begin
        if (ch_len != 9'd0 && ch_len_en) begin
          ch_len = ch_len - 9'd1;
          if (ch_len == 9'd0) ch_on = 1'b0;
        end
      end
      CMD_REG_WRITE: begin
        case (beat.reg_address)
          REG_DAC:     ch_dac = beat.write_data[7];
          REG_LENGTH:  ch_len = LENGTH_FULL - {1'b0, beat.write_data};
          REG_VOLUME:  ch_vol = beat.write_data[6:5];
          REG_FREQ_LO: ch_period[7:0] = beat.write_data;
          REG_FREQ_HI: begin
            ch_period[10:8] = beat.write_data[2:0];
            ch_len_en = beat.write_data[6];
            if (beat.write_data[7]) begin
              ch_on = 1'b1;
              if (ch_len == 9'd0) ch_len = LENGTH_FULL;
              ch_timer = timer_reload(ch_period);
              ch_pos = 5'd0;
            end
          end
          default: ;
        endcase
      end
      CMD_REG_READ: begin
        case (beat.reg_address)
          REG_DAC:     res.read_data = DAC_READ_MASK | {ch_dac, 7'd0};
          REG_VOLUME:  res.read_data = VOL_READ_MASK | {1'b0, ch_vol, 5'd0};
          REG_FREQ_HI: res.read_data = FREQ_READ_MASK | {1'b0, ch_len_en, 6'd0};
          default:     res.read_data = READ_IDLE;
        endcase
      end
      CMD_PATTERN_WRITE: ch_ram[beat.pattern_offset] = beat.write_data;
      CMD_PATTERN_READ:  res.read_data = ch_ram[beat.pattern_offset];
      CMD_POWER_OFF: begin
        ch_dac = 1'b0;
        ch_vol = 2'd0;
        ch_period = 11'd0;
        ch_len_en = 1'b0;
      end
      default: ;
    endcase
    res.sample_out = ch_sample;
    res.channel_active = ch_on;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_beat(input logic [2:0] cmd, input logic [7:0] addr,
                          input logic [3:0] offset, input logic [7:0] data);
    wsc_in_t beat;
    beat.cmd = cmd;
    beat.reg_address = addr;
    beat.pattern_offset = offset;
    beat.write_data = data;
    pending_beats.push_back(beat);
  endtask

  task automatic add_op(input logic [2:0] cmd);
    add_beat(cmd, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic add_reg_write(input logic [7:0] addr, input logic [7:0] data);
    add_beat(CMD_REG_WRITE, addr, 4'($urandom), data);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      ch_timer = TIMER_RESET;
      ch_pos = 5'd0;
      ch_len = 9'd0;
      ch_on = 1'b0;
      ch_dac = 1'b0;
      ch_vol = 2'd0;
      ch_period = 11'd0;
      ch_len_en = 1'b0;
      ch_sample = 4'd0;
      foreach (ch_ram[i]) ch_ram[i] = 8'h00;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_channel(in_data));
        beats_sent <= beats_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_beats.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else if (!holdoff_done && beats_sent >= HOLDOFF_START) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(8, 64);
      end
      pattern_left--;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  always @(posedge clk) begin
    wsc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", int'(out_data), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.sample_out !== want.sample_out)
          report_mismatch("sample_out", out_data.sample_out, want.sample_out);
        if (out_data.channel_active !== want.channel_active)
          report_mismatch("channel_active", out_data.channel_active, want.channel_active);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    int unsigned run;
    logic [7:0]  data;

    add_op(CMD_REG_READ);
    add_beat(CMD_REG_READ, REG_DAC, 4'd0, 8'h00);
    add_beat(CMD_REG_READ, REG_LENGTH, 4'd15, 8'hFF);
    add_beat(CMD_REG_READ, REG_VOLUME, 4'd0, 8'h00);
    add_beat(CMD_REG_READ, REG_FREQ_LO, 4'd0, 8'h00);
    add_beat(CMD_REG_READ, REG_FREQ_HI, 4'd0, 8'h00);
    add_beat(CMD_REG_READ, 8'hFF, 4'd0, 8'h00);
    add_beat(CMD_PATTERN_WRITE, 8'h00, 4'd0, 8'hF3);
    add_beat(CMD_PATTERN_WRITE, 8'hFF, 4'd15, 8'h00);
    add_beat(CMD_PATTERN_READ, 8'h00, 4'd0, 8'h00);
    add_beat(CMD_PATTERN_READ, 8'h00, 4'd15, 8'hFF);
    add_reg_write(REG_DAC, 8'h80);
    add_reg_write(REG_VOLUME, 8'h20);
    add_reg_write(REG_FREQ_LO, 8'hFF);
    add_reg_write(REG_LENGTH, 8'hFF);
    add_reg_write(REG_FREQ_HI, 8'hC7);
    repeat (4) add_op(CMD_TICK);
    add_op(CMD_LENGTH_CLOCK);
    add_op(CMD_LENGTH_CLOCK);
    add_reg_write(8'h00, 8'hFF);
    add_op(CMD_UNUSED);
    add_reg_write(REG_FREQ_LO, 8'h00);
    add_reg_write(REG_FREQ_HI, 8'h80);
    add_op(CMD_POWER_OFF);
    add_beat(CMD_REG_READ, REG_FREQ_HI, 4'd0, 8'h00);

    target = pending_beats.size() + RANDOM_BEATS;
    while (pending_beats.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_reg_write(REG_DAC, {1'($urandom_range(0, 4) != 0), 7'($urandom)});
          add_reg_write(REG_VOLUME, 8'($urandom));
          data = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(240, 255));
          add_reg_write(REG_FREQ_LO, data);
          if ($urandom_range(0, 1) == 1) begin
            data = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(230, 255));
            add_reg_write(REG_LENGTH, data);
          end
          data = {1'($urandom_range(0, 4) != 0), 1'($urandom), 3'($urandom),
                  ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'b111};
          add_reg_write(REG_FREQ_HI, data);
        end
        2, 3, 4: begin
          run = $urandom_range(4, 48);
          repeat (run) begin
            case ($urandom_range(0, 11))
              0: add_op(CMD_PATTERN_WRITE);
              1: add_op(CMD_LENGTH_CLOCK);
              default: add_op(CMD_TICK);
            endcase
          end
        end
        5: begin
          run = $urandom_range(1, 16);
          repeat (run) add_op(CMD_PATTERN_WRITE);
        end
        6: begin
          run = $urandom_range(1, 30);
          repeat (run) add_op(CMD_LENGTH_CLOCK);
        end
        7: begin
          run = $urandom_range(1, 6);
          repeat (run) begin
            if ($urandom_range(0, 1) == 1) begin
              add_op(CMD_PATTERN_READ);
            end else begin
              data = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(REG_DAC, REG_FREQ_HI));
              add_beat(CMD_REG_READ, data, 4'($urandom), 8'($urandom));
            end
          end
        end
        8: begin
          run = $urandom_range(1, 4);
          repeat (run) add_op(3'($urandom));
        end
        default: begin
          add_op(($urandom_range(0, 1) == 1) ? CMD_POWER_OFF : CMD_UNUSED);
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_results.size() != 0) begin
      report_mismatch("missing beat", 0, int'(expected_results.pop_front()));
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
